// File: hw/rtl/fbit_pkg.sv
package fbit_pkg;

  // Field widths of the request and result items
  localparam int IDX_W  = 10;
  localparam int SIZE_W = 11;
  localparam int VAL_W  = 32;
  localparam int MODE_W = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  // Request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 3'd0,
    MODE_SET    = 3'd1,
    MODE_PREFIX = 3'd2,
    MODE_RANGE  = 3'd3,
    MODE_LOWER  = 3'd4
  } mode_t;

  // Kinds of tree walk
  typedef enum logic [1:0] {
    WALK_DOWN = 2'd0,
    WALK_UP   = 2'd1,
    WALK_DESC = 2'd2
  } walk_kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_RUN_A = 3'd2,
    ST_RUN_B = 3'd3,
    ST_RUN_C = 3'd4,
    ST_DONE  = 3'd5
  } state_t;

  // Walk launch control
  typedef struct packed {
    logic       start;
    walk_kind_t kind;
  } walk_ctl_t;

endpackage

// File: hw/rtl/fbit_ram.sv
module fbit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/fbit_walk.sv
module fbit_walk #(
  parameter int DEPTH = 1024,
  parameter int VALUE_WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int KW = AW + 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fbit_pkg::walk_ctl_t    ctl,
  input  logic [KW-1:0]          start_k,
  input  logic [KW-1:0]          size_n,
  input  logic [VALUE_WIDTH-1:0] arg,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] acc,
  output logic [KW-1:0]          res,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  logic [VALUE_WIDTH-1:0] rd_data,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [VALUE_WIDTH-1:0] wr_data
);
  import fbit_pkg::*;

  logic                   active_r, active_nxt;
  walk_kind_t             kind_r, kind_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic [KW-1:0]          bit_r, bit_nxt;
  logic [KW-1:0]          res_r, res_nxt;
  logic [VALUE_WIDTH-1:0] arg_r, arg_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   pend_r, pend_nxt;
  logic [AW-1:0]          pend_addr_r, pend_addr_nxt;
  logic                   done_r, done_nxt;

  logic [KW-1:0]          lowbit;
  logic [KW-1:0]          cand;
  logic [KW-1:0]          top_bit;
  logic [KW-1:0]          addr_k;
  logic                   issue;
  logic [VALUE_WIDTH-1:0] sum;

  // Highest power of two not above the size; one when the size is zero
  always_comb begin
    top_bit = KW'(1);
    for (int i = 0; i < KW; i++) begin
      if (size_n[i]) begin
        top_bit = KW'(1) << i;
      end
    end
  end

  assign lowbit = k_r & (~k_r + KW'(1));
  assign cand   = res_r | bit_r;
  assign sum    = acc_r + rd_data;

  // Read issue for the current step
  always_comb begin
    issue  = 1'b0;
    addr_k = k_r - KW'(1);
    case (kind_r)
      WALK_DOWN: issue = active_r && (k_r != '0);
      WALK_UP:   issue = active_r && (k_r != '0) && (k_r <= size_n);
      WALK_DESC: begin
        issue  = active_r && !pend_r && (bit_r != '0) && (cand <= size_n);
        addr_k = cand - KW'(1);
      end
      default:   issue = 1'b0;
    endcase
  end

  assign rd_en   = issue;
  assign rd_addr = addr_k[AW-1:0];

  // Write back updated node in the cycle after its read
  assign wr_en   = active_r && pend_r && (kind_r == WALK_UP);
  assign wr_addr = pend_addr_r;
  assign wr_data = rd_data + arg_r;

  // Step the walk
  always_comb begin
    active_nxt    = active_r;
    kind_nxt      = kind_r;
    k_nxt         = k_r;
    bit_nxt       = bit_r;
    res_nxt       = res_r;
    arg_nxt       = arg_r;
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    done_nxt      = 1'b0;
    if (ctl.start) begin
      active_nxt = 1'b1;
      kind_nxt   = ctl.kind;
      k_nxt      = start_k;
      bit_nxt    = top_bit;
      res_nxt    = '0;
      arg_nxt    = arg;
      acc_nxt    = '0;
      pend_nxt   = 1'b0;
    end else if (active_r) begin
      pend_nxt      = issue;
      pend_addr_nxt = addr_k[AW-1:0];
      case (kind_r)
        WALK_DOWN: begin
          if (issue) k_nxt = k_r - lowbit;
          if (pend_r) acc_nxt = sum;
        end
        WALK_UP: begin
          if (issue) k_nxt = k_r + lowbit;
        end
        WALK_DESC: begin
          if (pend_r) begin
            if ($signed(sum) < $signed(arg_r)) begin
              res_nxt = cand;
              acc_nxt = sum;
            end
            bit_nxt = bit_r >> 1;
          end else if (!issue) begin
            bit_nxt = bit_r >> 1;
          end
        end
        default: ;
      endcase
      // Finish once nothing is issued, no read is in flight and, for a descent, no bit is left
      if (!issue && !pend_r && (kind_r != WALK_DESC || bit_r == '0)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pend_r   <= pend_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    k_r         <= k_nxt;
    bit_r       <= bit_nxt;
    res_r       <= res_nxt;
    arg_r       <= arg_nxt;
    acc_r       <= acc_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

  assign done = done_r;
  assign acc  = acc_r;
  assign res  = res_r;

  // Update walks visit strictly rising nodes, so no entry is written twice
  a_up_rising: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && $past(wr_en) && !$past(ctl.start) |-> wr_addr > $past(wr_addr))
    else $error("update walk wrote a node out of order");

  // Done is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("walk done held for more than one cycle");

  // Done only follows an idle read pipe
  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !active_r && !pend_r)
    else $error("walk finished with a read in flight");

endmodule

// File: hw/rtl/binary_indexed_prefix_sum_table_top.sv
// Fenwick tree of wrapping signed sums held in one synchronous RAM.
// Add and prefix sum take one tree walk, range sum two, set value three, lower bound one
// descent; a walk visits at most log2(size_in_use) + 1 nodes. Bad index, reversed range or
// unused mode answer without a walk. One node read per cycle; a descent waits for each read.
// A request is taken only while idle; a stalled result holds off the next request.
// Synchronous active-low reset, then a clearing pass over all DEPTH entries before the first request.
module binary_indexed_prefix_sum_table_top #(
  parameter int DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // request
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // index[9:0], index_hi[19:10], value[51:20], pad[55:52]
  input  logic [2:0]  in_tuser,   // mode[2:0]
  // result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // total[31:0], position[42:32], pad[47:43]
  output logic [0:0]  out_tuser,  // bad_index
  // size_in_use register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);
  import fbit_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW = AW + 2;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          clr_addr_r, clr_addr_nxt;
  logic [SIZE_W-1:0]      size_r;
  mode_t                  mode_r, mode_nxt;
  logic [IDX_W-1:0]       lo_r, lo_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [VALUE_WIDTH-1:0] a_r, a_nxt;
  logic [VALUE_WIDTH-1:0] res_total_r, res_total_nxt;
  logic [SIZE_W-1:0]      res_pos_r, res_pos_nxt;
  logic                   res_bad_r, res_bad_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]       out_total_r, out_total_nxt;
  logic [SIZE_W-1:0]      out_pos_r, out_pos_nxt;
  logic                   out_bad_r, out_bad_nxt;

  logic [IDX_W-1:0]       in_lo, in_hi;
  logic [VAL_W-1:0]       in_val;
  logic [63:0]            in_val64;
  logic [VALUE_WIDTH-1:0] in_val_ext;
  logic [KW-1:0]          n_cur;
  logic                   lo_bad, hi_bad;
  logic                   in_acc;
  logic                   out_take;

  walk_ctl_t              walk_ctl;
  logic [KW-1:0]          walk_k;
  logic [VALUE_WIDTH-1:0] walk_arg;
  logic                   walk_done;
  logic [VALUE_WIDTH-1:0] walk_acc;
  logic [KW-1:0]          walk_res;
  logic [31:0]            walk_res32;
  logic                   w_rd_en, w_wr_en;
  logic [AW-1:0]          w_rd_addr, w_wr_addr;
  logic [VALUE_WIDTH-1:0] w_wr_data, rd_data;
  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [VALUE_WIDTH-1:0] mem_wr_data;
  logic [VALUE_WIDTH+31:0] total_ext;

  // Unpack request fields
  assign in_lo      = in_tdata[9:0];
  assign in_hi      = in_tdata[19:10];
  assign in_val     = in_tdata[51:20];
  assign in_val64   = {{32{in_val[VAL_W-1]}}, in_val};
  assign in_val_ext = in_val64[VALUE_WIDTH-1:0];

  // Effective size saturates at the tree depth
  assign n_cur  = (32'(size_r) > 32'(DEPTH)) ? KW'(DEPTH) : KW'(size_r);
  assign lo_bad = 32'(in_lo) >= 32'(n_cur);
  assign hi_bad = 32'(in_hi) >= 32'(n_cur);

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_take   = !out_valid_r || out_tready;
  assign walk_res32 = 32'(walk_res);

  // Request sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    mode_nxt      = mode_r;
    lo_nxt        = lo_r;
    val_nxt       = val_r;
    a_nxt         = a_r;
    res_total_nxt = res_total_r;
    res_pos_nxt   = res_pos_r;
    res_bad_nxt   = res_bad_r;
    walk_ctl      = '{start: 1'b0, kind: WALK_DOWN};
    walk_k        = '0;
    walk_arg      = '0;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          mode_nxt      = mode_t'(in_tuser);
          lo_nxt        = in_lo;
          val_nxt       = in_val_ext;
          res_total_nxt = '0;
          res_pos_nxt   = '0;
          res_bad_nxt   = 1'b0;
          state_nxt     = ST_DONE;
          case (mode_t'(in_tuser))
            MODE_ADD: begin
              res_bad_nxt = lo_bad;
              if (!lo_bad) begin
                walk_ctl  = '{start: 1'b1, kind: WALK_UP};
                walk_k    = KW'(in_lo) + KW'(1);
                walk_arg  = in_val_ext;
                state_nxt = ST_RUN_A;
              end
            end
            MODE_SET, MODE_PREFIX: begin
              res_bad_nxt = lo_bad;
              if (!lo_bad) begin
                walk_ctl  = '{start: 1'b1, kind: WALK_DOWN};
                walk_k    = KW'(in_lo) + KW'(1);
                state_nxt = ST_RUN_A;
              end
            end
            MODE_RANGE: begin
              res_bad_nxt = lo_bad || hi_bad;
              // reversed bounds answer zero without a walk
              if (!lo_bad && !hi_bad && (in_lo <= in_hi)) begin
                walk_ctl  = '{start: 1'b1, kind: WALK_DOWN};
                walk_k    = KW'(in_hi) + KW'(1);
                state_nxt = ST_RUN_A;
              end
            end
            MODE_LOWER: begin
              walk_ctl  = '{start: 1'b1, kind: WALK_DESC};
              walk_arg  = in_val_ext;
              state_nxt = ST_RUN_A;
            end
            default: ;
          endcase
        end
      end
      ST_RUN_A: begin
        if (walk_done) begin
          state_nxt = ST_DONE;
          case (mode_r)
            MODE_PREFIX: res_total_nxt = walk_acc;
            MODE_LOWER:  res_pos_nxt   = walk_res32[SIZE_W-1:0];
            MODE_SET, MODE_RANGE: begin
              // second walk: prefix below the low index
              a_nxt     = walk_acc;
              walk_ctl  = '{start: 1'b1, kind: WALK_DOWN};
              walk_k    = KW'(lo_r);
              state_nxt = ST_RUN_B;
            end
            default: ;
          endcase
        end
      end
      ST_RUN_B: begin
        if (walk_done) begin
          state_nxt = ST_DONE;
          case (mode_r)
            MODE_RANGE: res_total_nxt = a_r - walk_acc;
            MODE_SET: begin
              // add new value minus current element
              walk_ctl  = '{start: 1'b1, kind: WALK_UP};
              walk_k    = KW'(lo_r) + KW'(1);
              walk_arg  = val_r - (a_r - walk_acc);
              state_nxt = ST_RUN_C;
            end
            default: ;
          endcase
        end
      end
      ST_RUN_C: begin
        if (walk_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register
  assign total_ext = {32'b0, res_total_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;
    out_pos_nxt   = out_pos_r;
    out_bad_nxt   = out_bad_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (state_r == ST_DONE && out_take) begin
      out_valid_nxt = 1'b1;
      out_total_nxt = total_ext[31:0];
      out_pos_nxt   = res_pos_r;
      out_bad_nxt   = res_bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      size_r      <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) size_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    lo_r        <= lo_nxt;
    val_r       <= val_nxt;
    a_r         <= a_nxt;
    res_total_r <= res_total_nxt;
    res_pos_r   <= res_pos_nxt;
    res_bad_r   <= res_bad_nxt;
    out_total_r <= out_total_nxt;
    out_pos_r   <= out_pos_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_pos_r, out_total_r};
  assign out_tuser  = out_bad_r;

  // Tree walk engine
  fbit_walk #(
    .DEPTH(DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (walk_ctl),
    .start_k (walk_k),
    .size_n  (n_cur),
    .arg     (walk_arg),
    .done    (walk_done),
    .acc     (walk_acc),
    .res     (walk_res),
    .rd_en   (w_rd_en),
    .rd_addr (w_rd_addr),
    .rd_data (rd_data),
    .wr_en   (w_wr_en),
    .wr_addr (w_wr_addr),
    .wr_data (w_wr_data)
  );

  // Clearing pass owns the write port after reset
  assign mem_wr_en   = (state_r == ST_CLEAR) || w_wr_en;
  assign mem_wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : w_wr_addr;
  assign mem_wr_data = (state_r == ST_CLEAR) ? '0 : w_wr_data;

  fbit_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_sums (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (w_rd_en),
    .rd_addr (w_rd_addr),
    .rd_data (rd_data)
  );

  // Walks never collide with the clearing pass
  a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !w_wr_en && !w_rd_en)
    else $error("tree walk active during clearing pass");

  // Walk completion only arrives while a walk is expected
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    walk_done |-> (state_r == ST_RUN_A || state_r == ST_RUN_B || state_r == ST_RUN_C))
    else $error("walk finished outside a run state");

  // A held result is only replaced after it was taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid_r) && !$past(out_tready) |-> out_valid_r && $stable(out_total_r))
    else $error("result dropped before acceptance");

endmodule

// File: bench/testbench.sv
module testbench;
  import fbit_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned PRINT_LIMIT = 40;
  localparam int unsigned SETTLE_CYCLES = 64;

  // Mode codes the block must answer with an all-zero result
  localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [VAL_W-1:0]  value;
  } request_t;

  typedef struct {
    logic [VAL_W-1:0]  total;
    logic [SIZE_W-1:0] position;
    logic              bad;
  } answer_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [55:0]       in_tdata = '0;   // index[9:0], index_hi[19:10], value[51:20], pad
  logic [MODE_W-1:0] in_tuser = '0;   // mode[2:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;       // total[31:0], position[42:32], pad
  logic [0:0]        out_tuser;       // bad_index
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data = '0;

  // Mirror of the tree: node k lives at entry k-1
  logic [VAL_W-1:0]  node_sum [DEPTH];
  logic [SIZE_W-1:0] size_reg = SIZE_RESET;
  answer_t           answer_queue [$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned answers_seen = 0;
  int unsigned size_writes = 0;
  int unsigned cycle_count = 0;

  binary_indexed_prefix_sum_table_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count,
               answer_queue.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic int unsigned live_size();
    return (size_reg > DEPTH) ? DEPTH : size_reg;
  endfunction

  // Sum of elements 0..count-1
  function automatic logic [VAL_W-1:0] sum_below(int unsigned count);
    logic [VAL_W-1:0] acc;
    int unsigned k;
    acc = '0;
    k = count;
    while (k > 0) begin
      acc = acc + node_sum[k-1];
      k = k - (k & (~k + 1));
    end
    return acc;
  endfunction

  function automatic void add_into(int unsigned idx, logic [VAL_W-1:0] delta, int unsigned n);
    int unsigned k;
    k = idx + 1;
    while (k <= n) begin
      node_sum[k-1] = node_sum[k-1] + delta;
      k = k + (k & (~k + 1));
    end
  endfunction

  // Count of leading elements whose running sum stays below target
  function automatic logic [SIZE_W-1:0] count_below(logic [VAL_W-1:0] target, int unsigned n);
    int unsigned top, pos, step;
    logic [VAL_W-1:0] run, trial;
    top = 1;
    pos = 0;
    run = '0;
    while ((top << 1) <= n) top = top << 1;
    for (step = top; step > 0; step = step >> 1) begin
      if ((pos | step) <= n) begin
        trial = run + node_sum[(pos | step) - 1];
        if ($signed(trial) < $signed(target)) begin
          pos = pos | step;
          run = trial;
        end
      end
    end
    return SIZE_W'(pos);
  endfunction

  // Apply one request to the mirror and return the answer it should produce
  function automatic answer_t answer_request(request_t r);
    answer_t a;
    int unsigned n;
    n = live_size();
    a.total = '0;
    a.position = '0;
    a.bad = 1'b0;
    case (r.mode)
      MODE_ADD: begin
        if (r.lo >= n) a.bad = 1'b1;
        else add_into(r.lo, r.value, n);
      end
      MODE_SET: begin
        if (r.lo >= n) a.bad = 1'b1;
        else add_into(r.lo, r.value - (sum_below(r.lo + 1) - sum_below(r.lo)), n);
      end
      MODE_PREFIX: begin
        if (r.lo >= n) a.bad = 1'b1;
        else a.total = sum_below(r.lo + 1);
      end
      MODE_RANGE: begin
        if (r.lo >= n || r.hi >= n) a.bad = 1'b1;
        else if (r.lo <= r.hi) a.total = sum_below(r.hi + 1) - sum_below(r.lo);
      end
      MODE_LOWER: begin
        a.position = count_below(r.value, n);
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("MISMATCH %s at result %0d: got %0h, expected %0h", what, answers_seen,
               got, want);
  endtask

  // Compare each delivered result with the oldest pending answer
  always @(posedge clk) begin : check_answers
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      answers_seen++;
      if (answer_queue.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], '0);
      end else begin
        want = answer_queue.pop_front();
        if (out_tdata[31:0] !== want.total)
          report_mismatch("total", out_tdata[31:0], want.total);
        if (out_tdata[42:32] !== want.position)
          report_mismatch("position", VAL_W'(out_tdata[42:32]), VAL_W'(want.position));
        if (out_tuser[0] !== want.bad)
          report_mismatch("bad_index", VAL_W'(out_tuser[0]), VAL_W'(want.bad));
      end
    end
  end

  // Offer one request, idling first at random; valid stays up for a following request
  task automatic send_request(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] lo,
                              logic [IDX_W-1:0] hi, logic [VAL_W-1:0] value);
    request_t r;
    r.mode = mode;
    r.lo = lo;
    r.hi = hi;
    r.value = value;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, value, hi, lo};
    in_tuser <= mode;
    do @(posedge clk); while (!in_tready);
    answer_queue.push_back(answer_request(r));
    requests_sent++;
  endtask

  // Drop valid and hold until every pending answer has come back
  task automatic wait_for_answers();
    in_tvalid <= 1'b0;
    while (answer_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    wait_for_answers();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = v;
    size_writes++;
  endtask

  function automatic logic [IDX_W-1:0] pick_index(int unsigned n);
    if (n == 0 || $urandom_range(99) < 12) return IDX_W'($urandom);
    return IDX_W'($urandom_range(n - 1));
  endfunction

  task automatic send_random_request();
    int unsigned n, pick;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0] lo, hi, swap;
    logic [VAL_W-1:0] value;
    n = live_size();
    pick = $urandom_range(99);
    if (pick < 25) mode = MODE_ADD;
    else if (pick < 40) mode = MODE_SET;
    else if (pick < 58) mode = MODE_PREFIX;
    else if (pick < 78) mode = MODE_RANGE;
    else if (pick < 95) mode = MODE_LOWER;
    else begin
      case ($urandom_range(2))
        0: mode = MODE_SPARE5;
        1: mode = MODE_SPARE6;
        default: mode = MODE_SPARE7;
      endcase
    end
    lo = pick_index(n);
    hi = pick_index(n);
    // Favor forward ranges
    if (lo > hi && $urandom_range(99) < 70) begin
      swap = lo;
      lo = hi;
      hi = swap;
    end
    pick = $urandom_range(99);
    if (pick < 10) value = $urandom;
    else if (pick < 14) value = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
    else value = $urandom_range(1200) - 200;
    // Aim most descents near a real prefix sum
    if (mode == MODE_LOWER && $urandom_range(99) < 70)
      value = sum_below($urandom_range(n)) + $urandom_range(2) - 1;
    send_request(mode, lo, hi, value);
  endtask

  task automatic test_cleared_store();
    send_request(MODE_PREFIX, 10'd1023, 10'd0, 32'd0);
    send_request(MODE_RANGE, 10'd0, 10'd1023, 32'd0);
    send_request(MODE_LOWER, 10'd0, 10'd0, 32'd0);
    send_request(MODE_LOWER, 10'd0, 10'd0, 32'd1);
  endtask

  task automatic test_extreme_values();
    send_request(MODE_ADD, 10'd0, 10'd0, 32'h7fff_ffff);
    send_request(MODE_ADD, 10'd1023, 10'd1023, 32'h8000_0000);
    send_request(MODE_ADD, 10'd512, 10'd0, 32'hffff_ffff);
    send_request(MODE_SET, 10'd1023, 10'd0, 32'd5);
    send_request(MODE_SET, 10'd0, 10'd0, 32'h8000_0000);
    send_request(MODE_PREFIX, 10'd0, 10'd0, 32'd0);
    send_request(MODE_PREFIX, 10'd1023, 10'd0, 32'd0);
    send_request(MODE_RANGE, 10'd512, 10'd512, 32'd0);
    // Reversed bounds answer zero
    send_request(MODE_RANGE, 10'd1023, 10'd0, 32'd0);
    send_request(MODE_RANGE, 10'd0, 10'd1023, 32'hffff_ffff);
    send_request(MODE_LOWER, 10'd0, 10'd0, 32'h8000_0000);
    send_request(MODE_LOWER, 10'd1023, 10'd1023, 32'h7fff_ffff);
  endtask

  task automatic test_unused_modes();
    send_request(MODE_SPARE5, 10'h3ff, 10'h3ff, 32'hffff_ffff);
    send_request(MODE_SPARE6, 10'd0, 10'h3ff, 32'h8000_0000);
    send_request(MODE_SPARE7, 10'h3ff, 10'd0, 32'h7fff_ffff);
  endtask

  task automatic test_size_extremes();
    // No elements: every indexed request is out of range
    write_size(11'd0);
    send_request(MODE_ADD, 10'd0, 10'd0, 32'd7);
    send_request(MODE_RANGE, 10'd0, 10'd0, 32'd0);
    send_request(MODE_LOWER, 10'd0, 10'd0, 32'h7fff_ffff);
    // One element: each range bound can be the bad one
    write_size(11'd1);
    send_request(MODE_PREFIX, 10'd0, 10'd0, 32'd0);
    send_request(MODE_PREFIX, 10'd1, 10'd0, 32'd0);
    send_request(MODE_RANGE, 10'd0, 10'd1, 32'd0);
    send_request(MODE_RANGE, 10'd1, 10'd0, 32'd0);
    send_request(MODE_LOWER, 10'd0, 10'd0, 32'h7fff_ffff);
    // Size beyond the store saturates
    write_size(11'h7ff);
    send_request(MODE_ADD, 10'd1023, 10'd0, 32'd1);
    send_request(MODE_PREFIX, 10'd1023, 10'd0, 32'd0);
    send_request(MODE_LOWER, 10'd0, 10'd0, 32'h7fff_ffff);
  endtask

  task automatic test_random_phase(int unsigned src_pct, int unsigned snk_pct,
                                   int unsigned item_count);
    int unsigned done_items, chunk;
    logic [SIZE_W-1:0] next_size;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    done_items = 0;
    while (done_items < item_count) begin
      case ($urandom_range(11))
        0: next_size = 11'd0;
        1: next_size = 11'd1;
        2, 3: next_size = 11'd1024;
        4: next_size = 11'h7ff;
        5, 6, 7: next_size = SIZE_W'($urandom_range(2, 64));
        default: next_size = SIZE_W'($urandom_range(65, 1023));
      endcase
      write_size(next_size);
      chunk = $urandom_range(60, 160);
      // Stop at the phase's item count
      if (chunk > item_count - done_items) chunk = item_count - done_items;
      repeat (chunk) send_random_request();
      done_items += chunk;
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) node_sum[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    src_idle_pct = 25;
    snk_idle_pct = 87;
    test_cleared_store();
    test_extreme_values();
    test_unused_modes();
    test_size_extremes();
    test_random_phase(25, 87, 585);
    test_random_phase(87, 25, 585);
    test_random_phase(0, 0, 585);
    wait_for_answers();
    // Catch any stray result after the last one due
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests over %0d size settings, checked %0d results, %0d mismatches",
             requests_sent, size_writes, answers_seen, mismatches);
    $display("Covered all five modes, unused codes, bad and reversed bounds, sizes 0 to 2047");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
